// ----- src/cwc_pkg.sv -----
`timescale 1ns / 1ps

package cwc_pkg;

  localparam int MaxQueueDefault = 16;
  localparam int TimeW = 48;
  localparam int SpanW = 32;
  localparam int SeqW = 32;
  localparam int CntW = 16;
  localparam int ResW = 8;
  localparam int LimitW = 5;
  localparam logic [LimitW-1:0] LimitReset = 5'd4;

  typedef enum logic [2:0] {
    FnRequest = 3'd0,
    FnObserve = 3'd1,
    FnFinish  = 3'd2,
    FnPop     = 3'd3,
    FnCancel  = 3'd4,
    FnStart   = 3'd5,
    FnStop    = 3'd6,
    FnUnused  = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    StNone      = 3'd0,
    StStarted   = 3'd1,
    StMerged    = 3'd2,
    StQueueFull = 3'd3,
    StStopped   = 3'd4,
    StFailed    = 3'd5,
    StQueued    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PhStopped   = 3'd0,
    PhBuilding  = 3'd1,
    PhCollect   = 3'd2,
    PhQueueFull = 3'd3,
    PhQueued    = 3'd4,
    PhIdle      = 3'd5
  } phase_e;

  typedef struct packed {
    logic [2:0]       func;
    logic [TimeW-1:0] time_value;
    logic [SpanW-1:0] pre_span;
    logic [SpanW-1:0] post_span;
    logic             trigger_automatic;
    logic [ResW-1:0]  trigger_resource;
    logic [CntW-1:0]  trigger_score;
    logic             snapshot_ok;
  } cwc_in_t;

  typedef struct packed {
    logic [2:0]       status_code;
    logic [2:0]       phase;
    logic [4:0]       queue_count;
    logic             req_open;
    logic             window_valid;
    logic [SeqW-1:0]  window_sequence;
    logic [TimeW-1:0] window_start;
    logic [TimeW-1:0] window_end;
    logic [CntW-1:0]  window_triggers;
    logic [CntW-1:0]  window_auto_triggers;
    logic [ResW-1:0]  window_best_resource;
    logic [CntW-1:0]  window_best_score;
  } cwc_out_t;

  typedef struct packed {
    logic [SeqW-1:0]  seq_no;
    logic [TimeW-1:0] t_start;
    logic [TimeW-1:0] t_end;
    logic [CntW-1:0]  triggers;
    logic [CntW-1:0]  auto_triggers;
    logic [ResW-1:0]  best_resource;
    logic [CntW-1:0]  best_score;
  } cwc_window_t;

  typedef struct packed {
    logic            accepting;
    logic            pending_valid;
    cwc_window_t     pending;
    logic            snapshot_busy;
    logic            last_rejected;
    logic [SeqW-1:0] next_seq;
  } cwc_state_t;

endpackage

// ----- src/cwc_step.sv -----
`timescale 1ns / 1ps

module cwc_step #(
  parameter int MaxQueue = cwc_pkg::MaxQueueDefault,
  parameter int QW = $clog2(MaxQueue + 1)
) (
  input  cwc_pkg::cwc_state_t          state_i,
  input  logic [QW-1:0]                queued_i,
  input  logic [cwc_pkg::LimitW-1:0]   limit_i,
  input  cwc_pkg::cwc_in_t             item_i,
  output cwc_pkg::cwc_state_t          state_o,
  output logic [QW-1:0]                queued_o,
  output cwc_pkg::cwc_out_t            res_o
);
  import cwc_pkg::*;

  localparam int CW = ((QW > LimitW) ? QW : LimitW) + 1;

  logic [CW-1:0]    lim;
  logic [CW-1:0]    rsv;
  logic [CW-1:0]    rsv_n;
  logic [TimeW:0]   diff;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] req_start;
  logic [TimeW-1:0] req_end;
  logic [2:0]       status;
  logic             wv;
  cwc_window_t      win;
  logic [2:0]       phase;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == {CntW{1'b1}}) ? v : v + CntW'(1);
  endfunction

  assign lim = (CW'(limit_i) < CW'(MaxQueue)) ? CW'(limit_i) : CW'(MaxQueue);
  assign rsv = CW'(queued_i) + CW'(state_i.snapshot_busy) + CW'(state_i.pending_valid);

  // clamp the window to the time range
  assign diff = {1'b0, item_i.time_value} - (TimeW+1)'(item_i.pre_span);
  assign sum  = {1'b0, item_i.time_value} + (TimeW+1)'(item_i.post_span);
  assign req_start = diff[TimeW] ? '0 : diff[TimeW-1:0];
  assign req_end   = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];

  always_comb begin
    state_o  = state_i;
    queued_o = queued_i;
    status   = StNone;
    wv       = 1'b0;
    win      = '0;
    case (item_i.func)
      FnRequest: begin
        if (!state_i.accepting) begin
          status = StStopped;
        end else if (state_i.pending_valid) begin
          if (req_start < state_i.pending.t_start) begin
            state_o.pending.t_start = req_start;
          end
          if (req_end > state_i.pending.t_end) begin
            state_o.pending.t_end = req_end;
          end
          state_o.pending.triggers = sat_inc(state_i.pending.triggers);
          if (item_i.trigger_automatic) begin
            state_o.pending.auto_triggers = sat_inc(state_i.pending.auto_triggers);
            if (item_i.trigger_score >= state_i.pending.best_score) begin
              state_o.pending.best_resource = item_i.trigger_resource;
              state_o.pending.best_score    = item_i.trigger_score;
            end
          end
          state_o.last_rejected = 1'b0;
          status = StMerged;
        end else if (rsv >= lim) begin
          state_o.last_rejected = 1'b1;
          status = StQueueFull;
        end else begin
          state_o.pending_valid         = 1'b1;
          state_o.pending.seq_no        = state_i.next_seq;
          state_o.next_seq              = state_i.next_seq + SeqW'(1);
          state_o.pending.t_start       = req_start;
          state_o.pending.t_end         = req_end;
          state_o.pending.triggers      = CntW'(1);
          state_o.pending.auto_triggers = CntW'(item_i.trigger_automatic);
          state_o.pending.best_resource =
            item_i.trigger_automatic ? item_i.trigger_resource : '0;
          state_o.pending.best_score    =
            item_i.trigger_automatic ? item_i.trigger_score : '0;
          state_o.last_rejected = 1'b0;
          status = StStarted;
        end
      end
      FnObserve: begin
        if (!state_i.snapshot_busy && state_i.pending_valid &&
            item_i.time_value >= state_i.pending.t_end) begin
          wv = 1'b1;
          win = state_i.pending;
          state_o.pending_valid = 1'b0;
          state_o.pending = '0;
          state_o.snapshot_busy = 1'b1;
        end
      end
      FnFinish: begin
        if (state_i.snapshot_busy) begin
          state_o.snapshot_busy = 1'b0;
          if (item_i.snapshot_ok && (CW'(queued_i) < lim)) begin
            queued_o = queued_i + QW'(1);
            state_o.last_rejected = 1'b0;
            status = StQueued;
          end else if (!item_i.snapshot_ok) begin
            status = StFailed;
          end else begin
            state_o.last_rejected = 1'b1;
            status = StQueueFull;
          end
        end
      end
      FnPop: begin
        if (queued_i != '0) begin
          queued_o = queued_i - QW'(1);
          status = StQueued;
        end
      end
      FnCancel: begin
        state_o.pending_valid = 1'b0;
        state_o.pending = '0;
      end
      FnStart: begin
        state_o.accepting = 1'b1;
      end
      FnStop: begin
        state_o.accepting = 1'b0;
        state_o.pending_valid = 1'b0;
        state_o.pending = '0;
      end
      default: begin
      end
    endcase
  end

  assign rsv_n = CW'(queued_o) + CW'(state_o.snapshot_busy) + CW'(state_o.pending_valid);

  always_comb begin
    if (!state_o.accepting) begin
      phase = PhStopped;
    end else if (state_o.snapshot_busy) begin
      phase = PhBuilding;
    end else if (state_o.pending_valid) begin
      phase = PhCollect;
    end else if (state_o.last_rejected) begin
      phase = PhQueueFull;
    end else if (queued_o != '0) begin
      phase = PhQueued;
    end else begin
      phase = PhIdle;
    end
  end

  always_comb begin
    res_o.status_code          = status;
    res_o.phase                = phase;
    res_o.queue_count          = 5'(queued_o);
    res_o.req_open             = state_o.accepting &&
                                 (state_o.pending_valid || (rsv_n < lim));
    res_o.window_valid         = wv;
    res_o.window_sequence      = win.seq_no;
    res_o.window_start         = win.t_start;
    res_o.window_end           = win.t_end;
    res_o.window_triggers      = win.triggers;
    res_o.window_auto_triggers = win.auto_triggers;
    res_o.window_best_resource = win.best_resource;
    res_o.window_best_score    = win.best_score;
  end

endmodule

// ----- src/capture_window_coordinator_unit.sv -----
`timescale 1ns / 1ps
// a request is held in the input register until the result register is free to load its result
// throughput: one request per cycle while the output is not stalled, with a combinational state update
// between the input register and the result register
// reset: clears all window and queue state, stops accepting, limit back to 4

module capture_window_coordinator_unit #(
  parameter int MaxQueue = cwc_pkg::MaxQueueDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cwc_pkg::cwc_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cwc_pkg::cwc_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [cwc_pkg::LimitW-1:0]   cfg_data_i
);
  import cwc_pkg::*;

  localparam int QW = $clog2(MaxQueue + 1);

  logic              in_valid_q;
  cwc_in_t           in_q;
  logic              out_valid_q;
  cwc_out_t          out_q;
  cwc_out_t          res_d;
  cwc_state_t        state_q;
  cwc_state_t        state_d;
  logic [QW-1:0]     queued_q;
  logic [QW-1:0]     queued_d;
  logic [LimitW-1:0] limit_q;
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  cwc_step #(
    .MaxQueue(MaxQueue),
    .QW      (QW)
  ) u_step (
    .state_i (state_q),
    .queued_i(queued_q),
    .limit_i (limit_q),
    .item_i  (in_q),
    .state_o (state_d),
    .queued_o(queued_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      queued_q    <= '0;
      limit_q     <= LimitReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        queued_q    <= queued_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/cwc_checker.sv -----
`timescale 1ns / 1ps

module cwc_checker #(
  parameter int MaxQueue = cwc_pkg::MaxQueueDefault
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input cwc_pkg::cwc_out_t            out_data_o
);
  import cwc_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a released window comes with status none and phase building
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.window_valid |->
      out_data_o.status_code == StNone && out_data_o.phase == PhBuilding)
    else $error("window release with wrong status or phase");

  // no release means empty window sequence, edges, trigger count and best score
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.window_valid |->
      out_data_o.window_sequence == '0 && out_data_o.window_start == '0 &&
      out_data_o.window_end == '0 && out_data_o.window_triggers == '0 &&
      out_data_o.window_best_score == '0)
    else $error("window fields set without release");

  // queue count stays within the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.queue_count) <= 32'(MaxQueue) ||
      MaxQueue > 31)
    else $error("queue count beyond depth");

  // stopped never offers a request slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.phase == PhStopped |-> !out_data_o.req_open)
    else $error("request slot offered while stopped");

endmodule

bind capture_window_coordinator_unit cwc_checker #(.MaxQueue(MaxQueue)) u_cwc_checker (.*);

// ----- sim/window_result_checker.sv -----
`timescale 1ns / 1ps

module window_result_checker #(
  parameter int MaxQueue = cwc_pkg::MaxQueueDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  cwc_pkg::cwc_in_t           in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  cwc_pkg::cwc_out_t          out_data_i,
  input  logic                       cfg_we_i,
  input  logic [cwc_pkg::LimitW-1:0] cfg_data_i,
  output int unsigned                n_wait_o,
  output int unsigned                n_err_o
);
  import cwc_pkg::*;

  logic              accepting_m;
  logic              pend_valid_m;
  cwc_window_t       pend_m;
  logic              busy_m;
  logic [4:0]        queued_m;
  logic              last_rej_m;
  logic [SeqW-1:0]   next_seq_m;
  logic [LimitW-1:0] limit_m;

  cwc_out_t expected_results[$];
  cwc_out_t oldest;

  function automatic int cap_now();
    return (int'(limit_m) < MaxQueue) ? int'(limit_m) : MaxQueue;
  endfunction

  function automatic int slots_used();
    return int'(queued_m) + int'(busy_m) + int'(pend_valid_m);
  endfunction

  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + CntW'(1);
  endfunction

  function automatic void clear_window();
    pend_valid_m = 1'b0;
    pend_m = '0;
  endfunction

  function automatic void reset_model();
    limit_m = LimitReset;
    accepting_m = 1'b0;
    clear_window();
    busy_m = 1'b0;
    queued_m = '0;
    last_rej_m = 1'b0;
    next_seq_m = '0;
  endfunction

  function automatic status_e take_trigger(input cwc_in_t d);
    logic [TimeW-1:0] lo;
    logic [TimeW-1:0] hi;
    logic [TimeW:0]   sum;
    if (!accepting_m) return StStopped;
    lo = (d.time_value >= {16'b0, d.pre_span}) ? d.time_value - {16'b0, d.pre_span} : '0;
    sum = {1'b0, d.time_value} + {17'b0, d.post_span};
    hi = sum[TimeW] ? '1 : sum[TimeW-1:0];
    if (pend_valid_m) begin
      if (lo < pend_m.t_start) pend_m.t_start = lo;
      if (hi > pend_m.t_end) pend_m.t_end = hi;
      pend_m.triggers = bump(pend_m.triggers);
      if (d.trigger_automatic) begin
        pend_m.auto_triggers = bump(pend_m.auto_triggers);
        if (d.trigger_score >= pend_m.best_score) begin
          pend_m.best_resource = d.trigger_resource;
          pend_m.best_score = d.trigger_score;
        end
      end
      last_rej_m = 1'b0;
      return StMerged;
    end
    if (slots_used() >= cap_now()) begin
      last_rej_m = 1'b1;
      return StQueueFull;
    end
    pend_valid_m = 1'b1;
    pend_m.seq_no = next_seq_m;
    next_seq_m = next_seq_m + SeqW'(1);
    pend_m.t_start = lo;
    pend_m.t_end = hi;
    pend_m.triggers = 16'd1;
    pend_m.auto_triggers = d.trigger_automatic ? 16'd1 : 16'd0;
    pend_m.best_resource = d.trigger_automatic ? d.trigger_resource : '0;
    pend_m.best_score = d.trigger_automatic ? d.trigger_score : '0;
    last_rej_m = 1'b0;
    return StStarted;
  endfunction

  function automatic cwc_out_t advance_coordinator(input cwc_in_t d);
    cwc_out_t r;
    phase_e   ph;
    r = '0;
    r.status_code = StNone;
    case (func_e'(d.func))
      FnRequest: r.status_code = take_trigger(d);
      FnObserve: begin
        if (!busy_m && pend_valid_m && d.time_value >= pend_m.t_end) begin
          r.window_valid = 1'b1;
          r.window_sequence = pend_m.seq_no;
          r.window_start = pend_m.t_start;
          r.window_end = pend_m.t_end;
          r.window_triggers = pend_m.triggers;
          r.window_auto_triggers = pend_m.auto_triggers;
          r.window_best_resource = pend_m.best_resource;
          r.window_best_score = pend_m.best_score;
          clear_window();
          busy_m = 1'b1;
        end
      end
      FnFinish: begin
        if (busy_m) begin
          busy_m = 1'b0;
          if (d.snapshot_ok && int'(queued_m) < cap_now()) begin
            queued_m = queued_m + 5'd1;
            last_rej_m = 1'b0;
            r.status_code = StQueued;
          end else if (!d.snapshot_ok) begin
            r.status_code = StFailed;
          end else begin
            last_rej_m = 1'b1;
            r.status_code = StQueueFull;
          end
        end
      end
      FnPop: begin
        if (queued_m != '0) begin
          queued_m = queued_m - 5'd1;
          r.status_code = StQueued;
        end
      end
      FnCancel: clear_window();
      FnStart: accepting_m = 1'b1;
      FnStop: begin
        accepting_m = 1'b0;
        clear_window();
      end
      default: ;
    endcase
    if (!accepting_m) ph = PhStopped;
    else if (busy_m) ph = PhBuilding;
    else if (pend_valid_m) ph = PhCollect;
    else if (last_rej_m) ph = PhQueueFull;
    else if (queued_m != '0) ph = PhQueued;
    else ph = PhIdle;
    r.phase = ph;
    r.queue_count = queued_m;
    r.req_open = accepting_m && (pend_valid_m || slots_used() < cap_now());
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    n_err_o++;
    if (n_err_o <= 100) begin
      $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  task automatic compare_result(input cwc_out_t got, input cwc_out_t want);
    if (got.status_code !== want.status_code)
      report("status_code", 64'(got.status_code), 64'(want.status_code));
    if (got.phase !== want.phase) report("phase", 64'(got.phase), 64'(want.phase));
    if (got.queue_count !== want.queue_count)
      report("queue_count", 64'(got.queue_count), 64'(want.queue_count));
    if (got.req_open !== want.req_open)
      report("req_open", 64'(got.req_open), 64'(want.req_open));
    if (got.window_valid !== want.window_valid)
      report("window_valid", 64'(got.window_valid), 64'(want.window_valid));
    if (got.window_sequence !== want.window_sequence)
      report("window_sequence", 64'(got.window_sequence), 64'(want.window_sequence));
    if (got.window_start !== want.window_start)
      report("window_start", 64'(got.window_start), 64'(want.window_start));
    if (got.window_end !== want.window_end)
      report("window_end", 64'(got.window_end), 64'(want.window_end));
    if (got.window_triggers !== want.window_triggers)
      report("window_triggers", 64'(got.window_triggers), 64'(want.window_triggers));
    if (got.window_auto_triggers !== want.window_auto_triggers)
      report("window_auto_triggers", 64'(got.window_auto_triggers),
             64'(want.window_auto_triggers));
    if (got.window_best_resource !== want.window_best_resource)
      report("window_best_resource", 64'(got.window_best_resource),
             64'(want.window_best_resource));
    if (got.window_best_score !== want.window_best_score)
      report("window_best_score", 64'(got.window_best_score),
             64'(want.window_best_score));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      expected_results.delete();
      n_err_o = 0;
      n_wait_o <= 0;
    end else begin
      if (cfg_we_i) limit_m = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", 64'(out_data_i.status_code), 64'd0);
        end else begin
          oldest = expected_results[0];
          expected_results.delete(0);
          compare_result(out_data_i, oldest);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.insert(expected_results.size(), advance_coordinator(in_data_i));
      n_wait_o <= expected_results.size();
    end
  end

endmodule

// ----- sim/capture_window_coordinator_unit_tb.sv -----
`timescale 1ns / 1ps

module capture_window_coordinator_unit_tb;
  import cwc_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int PhaseItems = 110;
  localparam int MergeRun = 100;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  cwc_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  cwc_out_t          out_data_o;
  logic              cfg_we_i;
  logic [LimitW-1:0] cfg_data_i;

  int unsigned      n_wait;
  int unsigned      n_err;
  int               quiet;
  int               sent;
  int               pop_pct;
  bit               idle_en;
  logic [TimeW-1:0] now_t;
  logic [TimeW-1:0] ends_seen;

  capture_window_coordinator_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  window_result_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .n_wait_o   (n_wait),
    .n_err_o    (n_err)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= idle_en ? ($urandom_range(99) >= 9) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [TimeW-1:0] rnd48();
    return {16'($urandom_range(65535)), 32'($urandom())};
  endfunction

  function automatic logic [TimeW-1:0] pick_time();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return rnd48();
      default: begin
        now_t = now_t + 48'($urandom_range(400));
        return now_t;
      end
    endcase
  endfunction

  function automatic logic [SpanW-1:0] pick_span();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return 32'($urandom_range(300));
    endcase
  endfunction

  function automatic cwc_in_t junk();
    cwc_in_t d;
    d.func = 3'($urandom_range(7));
    d.time_value = rnd48();
    d.pre_span = $urandom();
    d.post_span = $urandom();
    d.trigger_automatic = 1'($urandom_range(1));
    d.trigger_resource = 8'($urandom_range(255));
    d.trigger_score = 16'($urandom_range(65535));
    d.snapshot_ok = 1'($urandom_range(1));
    return d;
  endfunction

  function automatic cwc_in_t with_func(input func_e f);
    cwc_in_t d;
    d = junk();
    d.func = f;
    return d;
  endfunction

  function automatic cwc_in_t make_event(input func_e f, input logic [TimeW-1:0] t,
                                         input logic [SpanW-1:0] pre,
                                         input logic [SpanW-1:0] post, input logic a,
                                         input logic [ResW-1:0] res,
                                         input logic [CntW-1:0] sc, input logic ok);
    cwc_in_t d;
    d.func = f;
    d.time_value = t;
    d.pre_span = pre;
    d.post_span = post;
    d.trigger_automatic = a;
    d.trigger_resource = res;
    d.trigger_score = sc;
    d.snapshot_ok = ok;
    return d;
  endfunction

  function automatic logic [LimitW-1:0] pick_limit(input int ph);
    case (ph)
      0: return 5'd1;
      1: return 5'd2;
      2: return 5'd16;
      3: return 5'd31;
      4: return 5'd0;
      5: return 5'd17;
      6: return 5'd3;
      7: return 5'd8;
      default: return 5'($urandom_range(31));
    endcase
  endfunction

  task automatic send(input cwc_in_t d);
    while (idle_en && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (n_wait != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_capture();
    int               n;
    cwc_in_t          d;
    logic [TimeW-1:0] obs;
    logic [TimeW:0]   reach;
    n = $urandom_range(1, 4);
    repeat (n) begin
      d = with_func(FnRequest);
      d.time_value = pick_time();
      d.pre_span = pick_span();
      d.post_span = pick_span();
      if ($urandom_range(3) == 0) d.trigger_score = 16'($urandom_range(3));
      reach = {1'b0, d.time_value} + {17'b0, d.post_span};
      if (reach[TimeW]) reach = {1'b0, {TimeW{1'b1}}};
      if (reach[TimeW-1:0] > ends_seen) ends_seen = reach[TimeW-1:0];
      send(d);
      if ($urandom_range(99) < pop_pct) send(with_func(FnPop));
    end
    if ($urandom_range(3) == 0 && ends_seen != 0) begin
      d = with_func(FnObserve);
      d.time_value = ends_seen - 48'd1;
      send(d);
    end
    if ($urandom_range(99) < 5) send(with_func(FnCancel));
    if ($urandom_range(99) < 4) begin
      send(with_func(FnStop));
      if ($urandom_range(1)) send(with_func(FnRequest));
      send(with_func(FnStart));
    end
    d = with_func(FnObserve);
    case ($urandom_range(9))
      0: obs = '1;
      1, 2, 3, 4: obs = ends_seen;
      default: begin
        obs = ends_seen + 48'($urandom_range(50));
        if (obs < ends_seen) obs = '1;
      end
    endcase
    d.time_value = obs;
    send(d);
    ends_seen = '0;
    d = with_func(FnFinish);
    d.snapshot_ok = ($urandom_range(9) != 0);
    send(d);
    if ($urandom_range(99) < pop_pct) send(with_func(FnPop));
  endtask

  initial begin
    int ph;
    int mark;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    idle_en = 1'b1;
    pop_pct = 30;
    sent = 0;
    now_t = '0;
    ends_seen = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limit, stopped then accepting, saturating window edges, score ties
    send(make_event(FnRequest, '0, '1, '1, 1'b1, 8'hff, 16'hffff, 1'b1));
    send(make_event(FnFinish, '1, '1, '1, 1'b1, 8'hff, 16'hffff, 1'b1));
    send(make_event(FnPop, '1, '0, '0, 1'b0, 8'h00, 16'h0000, 1'b0));
    send(make_event(FnUnused, '1, '1, '1, 1'b1, 8'hff, 16'hffff, 1'b1));
    send(make_event(FnStart, '0, '0, '0, 1'b0, 8'h00, 16'h0000, 1'b0));
    send(make_event(FnRequest, 48'd100, '1, '0, 1'b0, 8'haa, 16'hffff, 1'b0));
    send(make_event(FnRequest, '1, '0, '1, 1'b1, 8'h55, 16'h0000, 1'b0));
    send(make_event(FnRequest, 48'd1000, 32'd10, 32'd10, 1'b1, 8'h01, 16'h0000, 1'b0));
    send(make_event(FnRequest, 48'd5, 32'd5, 32'd5, 1'b1, 8'h00, 16'hffff, 1'b0));
    send(make_event(FnRequest, 48'd7, 32'd1, 32'd1, 1'b1, 8'h77, 16'd100, 1'b0));
    send(make_event(FnObserve, 48'hffff_ffff_fffe, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnObserve, '1, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnRequest, 48'd50, 32'd100, 32'd20, 1'b1, 8'h12, 16'd9, 1'b0));
    send(make_event(FnObserve, '1, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnFinish, '0, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnObserve, 48'd70, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnFinish, '0, '0, '0, 1'b0, 8'h00, 16'h0, 1'b1));
    send(make_event(FnPop, '0, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnRequest, 48'd300, 32'd3, 32'd3, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnCancel, '0, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnRequest, 48'd400, 32'd3, 32'd3, 1'b1, 8'h34, 16'd5, 1'b0));
    send(make_event(FnStop, '0, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnObserve, '1, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));

    // no slots at all
    write_limit(5'd0);
    send(make_event(FnStart, '0, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnRequest, 48'd10, 32'd1, 32'd1, 1'b1, 8'h01, 16'd1, 1'b0));
    send(make_event(FnObserve, '1, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));

    // limit clamped, long merge run without idling
    write_limit(5'd31);
    idle_en <= 1'b0;
    repeat (MergeRun) begin
      send(make_event(FnRequest, 48'(1000 + $urandom_range(1000)), 32'($urandom_range(20)),
                      32'($urandom_range(20)), 1'b1, 8'($urandom_range(255)),
                      16'($urandom_range(65535)), 1'b0));
    end
    send(make_event(FnObserve, 48'd5000, '0, '0, 1'b0, 8'h00, 16'h0, 1'b0));
    send(make_event(FnFinish, '0, '0, '0, 1'b0, 8'h00, 16'h0, 1'b1));

    for (ph = 0; ph < 10; ph++) begin
      write_limit(pick_limit(ph));
      idle_en <= (ph != 5);
      pop_pct = $urandom_range(10, 60);
      send(with_func(FnStart));
      mark = sent;
      while (sent - mark < PhaseItems) begin
        if ($urandom_range(99) < 80) run_capture();
        else send(junk());
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (n_err == 0 && n_wait == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
